### design/gai_pkg.sv
// Shared types and constants for the gyro angle integrator.
// Used by gai_axis and gyro_angle_integrator; depends on nothing else.
package gai_pkg;

  localparam int AXIS_COUNT    = 3;
  localparam int BYTE_W        = 8;
  localparam int RATE_W        = 16;
  localparam int DEADBAND_W    = 15;
  localparam int SCALE_W       = 20;
  localparam int CFG_DATA_W    = 20;
  localparam int FULL_TURN_DEG = 360;

  // Reset values of the configuration registers
  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = DEADBAND_W'(57);
  localparam logic [SCALE_W-1:0]    SCALE_RESET    = SCALE_W'(11744);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_DEADBAND = 1'b0,
    REG_SCALE    = 1'b1
  } cfg_reg_t;

  // One axis of a sample: new-data flag and the two rate bytes
  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
  } axis_sample_t;

endpackage

### design/gyro_angle_integrator.sv
// Top level of the gyro angle integrator: input stage, accumulators, result stage.
// Depends on gai_pkg and gai_axis.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one three-axis sample per
//   transaction: axis_valid mask and a low and high byte per axis. A sample
//   whose mask is zero is consumed and dropped without a result.
//   Output channel (out_valid / out_stall) carries one result per sample with
//   a nonzero mask: updated_axes, the per-axis rate after the deadband, and
//   the three accumulated angles (degrees, ANGLE_FRAC_BITS fraction bits).
//   Config channel (cfg_valid / cfg_ready) writes deadband_counts (index 0)
//   or degrees_per_count_q24 (index 1); cfg_ready is always high. Write it
//   only while no sample is in flight.
// Timing:
//   A sample lands in the input register at its accepting edge, the axis
//   datapath (one 16x21 multiply, add and wrap per axis) works on it from
//   there, and the result register is loaded once the result stage is free,
//   which raises out_valid. One sample per cycle sustained while out_stall
//   stays low; the accumulator update through the multiply-add-wrap path
//   sets that rate.
// Reset: clears both stages, zeroes the accumulators and restores the
//   config registers to their defaults.
// Stall: a stalled result holds; the input register keeps one more sample,
//   and in_stall rises only when both stages are full.
module gyro_angle_integrator #(
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         axis_valid,
  input  logic [7:0]                         x_low_byte,
  input  logic [7:0]                         x_high_byte,
  input  logic [7:0]                         y_low_byte,
  input  logic [7:0]                         y_high_byte,
  input  logic [7:0]                         z_low_byte,
  input  logic [7:0]                         z_high_byte,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         updated_axes,
  output logic signed [gai_pkg::RATE_W-1:0]  x_rate,
  output logic signed [gai_pkg::RATE_W-1:0]  y_rate,
  output logic signed [gai_pkg::RATE_W-1:0]  z_rate,
  output logic [ANGLE_FRAC_BITS+8:0]         x_angle,
  output logic [ANGLE_FRAC_BITS+8:0]         y_angle,
  output logic [ANGLE_FRAC_BITS+8:0]         z_angle,
  // config channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  gai_pkg::cfg_reg_t                  cfg_index,
  input  logic [gai_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gai_pkg::*;

  localparam int ANGLE_W = ANGLE_FRAC_BITS + 9;
  localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(FULL_TURN_DEG) << ANGLE_FRAC_BITS;

  // Config registers
  logic [DEADBAND_W-1:0] deadband_counts;
  logic [SCALE_W-1:0]    degrees_per_count_q24;

  // Input register
  logic         s1_valid;
  axis_sample_t s1_sample [AXIS_COUNT];
  axis_sample_t s1_sample_next [AXIS_COUNT];

  // Accumulators and datapath results
  logic [ANGLE_W-1:0]       angle_acc  [AXIS_COUNT];
  logic [ANGLE_W-1:0]       angle_next [AXIS_COUNT];
  logic signed [RATE_W-1:0] rate_next  [AXIS_COUNT];

  // Result register
  logic [2:0]               mask_q;
  logic signed [RATE_W-1:0] rate_q  [AXIS_COUNT];
  logic [ANGLE_W-1:0]       angle_q [AXIS_COUNT];

  logic in_accept;
  logic out_load_ok;
  logic s1_advance;

  // Handshake: the result stage frees up when empty or being taken
  assign out_load_ok = !out_valid || !out_stall;
  assign s1_advance  = s1_valid && out_load_ok;
  assign in_stall    = s1_valid && !out_load_ok;
  assign in_accept   = in_valid && !in_stall;
  assign cfg_ready   = 1'b1;

  always_comb begin
    s1_sample_next[0] = '{en: axis_valid[0], lo: x_low_byte, hi: x_high_byte};
    s1_sample_next[1] = '{en: axis_valid[1], lo: y_low_byte, hi: y_high_byte};
    s1_sample_next[2] = '{en: axis_valid[2], lo: z_low_byte, hi: z_high_byte};
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband_counts       <= DEADBAND_RESET;
      degrees_per_count_q24 <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEADBAND: deadband_counts       <= cfg_data[DEADBAND_W-1:0];
        REG_SCALE:    degrees_per_count_q24 <= cfg_data[SCALE_W-1:0];
        default:      ;
      endcase
    end
  end

  // Input stage: drop samples with no axis flagged right here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= |axis_valid;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample <= s1_sample_next;
    end
  end

  // Per-axis datapath
  for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_axis
    gai_axis #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_axis (
      .sample     (s1_sample[g]),
      .deadband   (deadband_counts),
      .scale      (degrees_per_count_q24),
      .angle      (angle_acc[g]),
      .rate       (rate_next[g]),
      .angle_next (angle_next[g])
    );
  end

  // Advance the accumulators together with the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        angle_acc[i] <= '0;
      end
    end else if (s1_advance) begin
      angle_acc <= angle_next;
    end
  end

  // Result stage: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      mask_q  <= {s1_sample[2].en, s1_sample[1].en, s1_sample[0].en};
      rate_q  <= rate_next;
      angle_q <= angle_next;
    end
  end

  assign updated_axes = mask_q;
  assign x_rate       = rate_q[0];
  assign y_rate       = rate_q[1];
  assign z_rate       = rate_q[2];
  assign x_angle      = angle_q[0];
  assign y_angle      = angle_q[1];
  assign z_angle      = angle_q[2];

  // Checks
  a_result_has_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> updated_axes != 3'b000)
    else $error("result with empty axis mask");

  a_acc_in_range: assert property (@(posedge clk) disable iff (rst)
    angle_acc[0] <= FULL_TURN && angle_acc[1] <= FULL_TURN && angle_acc[2] <= FULL_TURN)
    else $error("angle accumulator beyond full turn");

  a_idle_axis_zero_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (updated_axes[0] || x_rate == 0) && (updated_axes[1] || y_rate == 0)
                  && (updated_axes[2] || z_rate == 0))
    else $error("nonzero rate on an axis not updated");

  a_acc_holds: assert property (@(posedge clk) disable iff (rst)
    !s1_advance |=> $stable(angle_acc[0]) && $stable(angle_acc[1]) && $stable(angle_acc[2]))
    else $error("accumulator moved without a sample");

  a_result_tracks_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> x_angle == angle_acc[0] && y_angle == angle_acc[1] && z_angle == angle_acc[2])
    else $error("result angle differs from accumulator");

endmodule

### design/gai_axis.sv
// Per-axis datapath: rate assembly, deadband, scale multiply and angle wrap.
// Purely combinational; depends on gai_pkg.
module gai_axis #(
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  gai_pkg::axis_sample_t               sample,
  input  logic [gai_pkg::DEADBAND_W-1:0]      deadband,
  input  logic [gai_pkg::SCALE_W-1:0]         scale,
  input  logic [ANGLE_FRAC_BITS+8:0]          angle,
  output logic signed [gai_pkg::RATE_W-1:0]   rate,
  output logic [ANGLE_FRAC_BITS+8:0]          angle_next
);
  import gai_pkg::*;

  localparam int ANGLE_W = ANGLE_FRAC_BITS + 9;
  localparam int PROD_W  = RATE_W + SCALE_W + 1;
  localparam int SUM_W   = ((ANGLE_W + 1 > PROD_W) ? ANGLE_W + 1 : PROD_W) + 1;
  localparam logic signed [SUM_W-1:0] TURN = SUM_W'(FULL_TURN_DEG) << ANGLE_FRAC_BITS;

  logic signed [RATE_W-1:0] raw;
  logic signed [RATE_W:0]   raw_ext;
  logic        [RATE_W:0]   mag;
  logic                     in_band;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  wrap_lo;
  logic signed [SUM_W-1:0]  wrap_hi;
  logic signed [SUM_W-1:0]  clamped;

  always_comb begin
    raw     = {sample.hi, sample.lo};
    raw_ext = {raw[RATE_W-1], raw};
    mag     = (raw_ext < 0) ? -raw_ext : raw_ext;
    in_band = mag <= {2'b00, deadband};
    rate    = (!sample.en || in_band) ? '0 : raw;

    prod = PROD_W'(rate) * PROD_W'($signed({1'b0, scale}));
    sum  = $signed({{(SUM_W - ANGLE_W){1'b0}}, angle}) + SUM_W'(prod);

    // One wrap each way, then clamp what a single wrap cannot fix
    wrap_lo = (sum < 0) ? sum + TURN : sum;
    wrap_hi = (wrap_lo > TURN) ? wrap_lo - TURN : wrap_lo;
    if (wrap_hi < 0) begin
      clamped = '0;
    end else if (wrap_hi > TURN) begin
      clamped = TURN;
    end else begin
      clamped = wrap_hi;
    end

    angle_next = sample.en ? clamped[ANGLE_W-1:0] : angle;
  end

endmodule

### verif/gyro_angle_integrator_tb.sv
// Self-checking testbench for gyro_angle_integrator: drives gyro samples and
// register writes, predicts the rate and angle results, and checks each one.
// Depends on gai_pkg and the gyro_angle_integrator RTL.
import gai_pkg::*;

localparam int FRAC_BITS = 24;
localparam int ANGLE_W   = FRAC_BITS + 9;

// One sample as offered on the input channel: mask plus a 16-bit word per axis
typedef struct packed {
  logic [AXIS_COUNT-1:0]             mask;
  logic [AXIS_COUNT-1:0][RATE_W-1:0] word;
} gyro_sample_t;

// One result as seen on the output channel
typedef struct packed {
  logic [AXIS_COUNT-1:0]              axes;
  logic [AXIS_COUNT-1:0][RATE_W-1:0]  rate;
  logic [AXIS_COUNT-1:0][ANGLE_W-1:0] angle;
} gyro_result_t;

// Tracks the register settings and the three angle accumulators, and keeps
// the results still owed by the block in order.
class angle_tracker;
  logic [DEADBAND_W-1:0] deadband;
  logic [SCALE_W-1:0]    scale;
  longint                acc[AXIS_COUNT];
  gyro_result_t          pending[$];
  int                    mismatches;

  function new();
    deadband   = DEADBAND_RESET;
    scale      = SCALE_RESET;
    mismatches = 0;
    foreach (acc[k]) acc[k] = 0;
  endfunction

  function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_DEADBAND) deadband = data[DEADBAND_W-1:0];
    else scale = data[SCALE_W-1:0];
  endfunction

  // Add one step, wrap once, then clamp whatever a single wrap cannot fix
  function longint integrate(longint start, int raw);
    longint turn;
    longint a;
    turn = longint'(FULL_TURN_DEG) <<< FRAC_BITS;
    a = start + longint'(raw) * longint'(scale);
    if (a < 0) a += turn;
    if (a > turn) a -= turn;
    if (a < 0) a = 0;
    if (a > turn) a = turn;
    return a;
  endfunction

  function void take_sample(gyro_sample_t s);
    gyro_result_t want;
    int raw;
    int mag;
    if (s.mask == '0) return;
    want.axes = s.mask;
    want.rate = '0;
    for (int k = 0; k < AXIS_COUNT; k++) begin
      if (s.mask[k]) begin
        raw = $signed(s.word[k]);
        mag = (raw < 0) ? -raw : raw;
        if (mag <= int'(deadband)) raw = 0;
        want.rate[k] = raw[RATE_W-1:0];
        acc[k] = integrate(acc[k], raw);
      end
      want.angle[k] = acc[k][ANGLE_W-1:0];
    end
    pending.push_back(want);
  endfunction

  function void note_mismatch(string field, longint want, longint got);
    mismatches++;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endfunction

  function void check_result(gyro_result_t got);
    gyro_result_t want;
    string axis_name[AXIS_COUNT] = '{"x", "y", "z"};
    if (pending.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing expected, axes %0d x_angle %0d",
               $time, got.axes, got.angle[0]);
      return;
    end
    want = pending.pop_front();
    if (got.axes != want.axes) note_mismatch("updated_axes", want.axes, got.axes);
    for (int k = 0; k < AXIS_COUNT; k++) begin
      if (got.rate[k] != want.rate[k])
        note_mismatch({axis_name[k], "_rate"}, $signed(want.rate[k]), $signed(got.rate[k]));
      if (got.angle[k] != want.angle[k])
        note_mismatch({axis_name[k], "_angle"}, want.angle[k], got.angle[k]);
    end
  endfunction
endclass

module gyro_angle_integrator_tb;

  localparam int RESET_CYCLES   = 6;
  // Margin after the last owed result so a dropped sample can clear
  localparam int SETTLE_CYCLES  = 4;
  // Long receiver hold-off used to fill the pipeline and back-pressure input
  localparam int HOLD_CYCLES    = 80;
  // Longest correct quiet stretch is the hold-off above plus a random stall
  // run; allow many times that before giving up
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  logic [2:0]                   axis_valid  = '0;
  logic [7:0]                   x_low_byte  = '0;
  logic [7:0]                   x_high_byte = '0;
  logic [7:0]                   y_low_byte  = '0;
  logic [7:0]                   y_high_byte = '0;
  logic [7:0]                   z_low_byte  = '0;
  logic [7:0]                   z_high_byte = '0;

  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  logic [2:0]                   updated_axes;
  logic signed [RATE_W-1:0]     x_rate;
  logic signed [RATE_W-1:0]     y_rate;
  logic signed [RATE_W-1:0]     z_rate;
  logic [ANGLE_W-1:0]           x_angle;
  logic [ANGLE_W-1:0]           y_angle;
  logic [ANGLE_W-1:0]           z_angle;

  logic                         cfg_valid   = 1'b0;
  logic                         cfg_ready;
  cfg_reg_t                     cfg_index   = REG_DEADBAND;
  logic [CFG_DATA_W-1:0]        cfg_data    = '0;

  angle_tracker tracker;

  // Idle and stall odds in percent, changed per phase by the main sequence
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  // Hold-off request for the receiver; the receiver counts the stretch itself
  bit hold_request = 1'b0;
  int hold_left    = 0;

  int quiet_cycles = 0;

  gyro_sample_t seen_sample;
  gyro_result_t seen_result;

  gyro_angle_integrator #(.ANGLE_FRAC_BITS(FRAC_BITS)) uut (.*);

  always #10 clk = ~clk;

  // Receiver: honor a pending hold-off first, else stall at the phase's odds
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Monitor: sample both channels with the values that held before the edge
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      seen_sample.mask = axis_valid;
      seen_sample.word = {z_high_byte, z_low_byte, y_high_byte, y_low_byte,
                          x_high_byte, x_low_byte};
      tracker.take_sample(seen_sample);
    end
    if (!rst && out_valid && !out_stall) begin
      seen_result.axes  = updated_axes;
      seen_result.rate  = {z_rate, y_rate, x_rate};
      seen_result.angle = {z_angle, y_angle, x_angle};
      tracker.check_result(seen_result);
    end
  end

  // Watchdog: end the run when no channel moves a transaction for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one sample, idling first at the phase's odds; return right after the
  // edge that accepted it, with valid still high
  task automatic send_sample(input gyro_sample_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    axis_valid  <= s.mask;
    x_low_byte  <= s.word[0][7:0];
    x_high_byte <= s.word[0][15:8];
    y_low_byte  <= s.word[1][7:0];
    y_high_byte <= s.word[1][15:8];
    z_low_byte  <= s.word[2][7:0];
    z_high_byte <= s.word[2][15:8];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send(input logic [2:0] mask, input logic [15:0] xw, input logic [15:0] yw,
                      input logic [15:0] zw);
    gyro_sample_t s;
    s.mask = mask;
    s.word = {zw, yw, xw};
    send_sample(s);
  endtask

  // Pick a rate word: full random, hugging the deadband edge, an extreme, or small
  function automatic logic [15:0] pick_rate(input int db);
    int mag;
    logic [15:0] w;
    case ($urandom_range(3))
      0: w = 16'($urandom);
      1: begin
        mag = db + int'($urandom_range(2)) - 1;
        w = 16'(mag);
        if ($urandom_range(1)) w = -w;
      end
      2: begin
        case ($urandom_range(3))
          0: w = 16'h8000;
          1: w = 16'h7fff;
          2: w = 16'h0000;
          default: w = 16'hffff;
        endcase
      end
      default: begin
        w = 16'($urandom_range(255));
        if ($urandom_range(1)) w = -w;
      end
    endcase
    return w;
  endfunction

  task automatic random_burst(input int count);
    for (int n = 0; n < count; n++)
      send(3'($urandom_range(7)), pick_rate(tracker.deadband), pick_rate(tracker.deadband),
           pick_rate(tracker.deadband));
  endtask

  // Drop valid, wait for every owed result, then let any dropped sample clear
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back, holding valid across the pair
  task automatic write_regs(input logic [DEADBAND_W-1:0] db, input logic [SCALE_W-1:0] sc);
    cfg_valid <= 1'b1;
    cfg_index <= REG_DEADBAND;
    cfg_data  <= CFG_DATA_W'(db);
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(REG_DEADBAND, CFG_DATA_W'(db));
    cfg_index <= REG_SCALE;
    cfg_data  <= CFG_DATA_W'(sc);
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(REG_SCALE, CFG_DATA_W'(sc));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Default settings, no idling. Directed corners first.
    write_regs(DEADBAND_RESET, SCALE_RESET);
    send(3'b000, 16'h1234, 16'h8000, 16'h7fff);  // empty mask: no result, no state change
    send(3'b001, 16'h8000, 16'h0000, 16'h0000);  // full-scale negative, wraps below zero
    send(3'b010, 16'h0000, 16'h7fff, 16'h0000);  // full-scale positive on y only
    send(3'b100, 16'h0000, 16'h0000, 16'd57);    // right at the deadband: zero
    send(3'b100, 16'h0000, 16'h0000, 16'd58);    // just past the deadband
    send(3'b001, -16'sd57, 16'h0000, 16'h0000);  // negative edge of the deadband
    send(3'b001, -16'sd58, 16'h0000, 16'h0000);
    send(3'b111, 16'h0000, 16'h0000, 16'h0000);
    send(3'b111, 16'hffff, 16'hffff, 16'hffff);
    send(3'b011, 16'h00ff, 16'hff00, 16'h5a5a);  // low/high byte halves set apart
    send(3'b101, 16'h7fff, 16'h1111, 16'h8000);
    send(3'b110, 16'h2222, 16'hc000, 16'h4000);
    send(3'b001, 16'h7fff, 16'h0000, 16'h0000);  // full-scale positive on x, twice in a row
    send(3'b001, 16'h7fff, 16'h0000, 16'h0000);

    // Hold the receiver off while the sender keeps offering, so input stalls
    hold_request = 1'b1;
    random_burst(100);
    settle();

    // Smallest deadband, largest scale: single wrap overshoots, clamp kicks in
    write_regs('0, '1);
    tx_idle_pct = 73;
    send(3'b111, 16'h0001, 16'hffff, 16'h0000);
    send(3'b111, 16'h7fff, 16'h8000, 16'h7fff);
    send(3'b001, 16'h8000, 16'h0000, 16'h0000);
    random_burst(100);
    settle();

    // Widest deadband, zero scale: only -32768 escapes, angles stand still
    write_regs('1, '0);
    tx_idle_pct  = 0;
    rx_stall_pct = 73;
    send(3'b111, 16'h8000, 16'h7fff, 16'h8001);
    send(3'b111, 16'h8000, 16'h8000, 16'h8000);
    random_burst(100);
    settle();

    // Random mid-range settings, both sides idling
    write_regs(DEADBAND_W'($urandom_range(300)), SCALE_W'($urandom_range(20000)));
    tx_idle_pct  = 32;
    rx_stall_pct = 32;
    random_burst(200);
    settle();

    // Back to the defaults at full speed
    write_regs(DEADBAND_RESET, SCALE_RESET);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    random_burst(200);
    settle();

    // Random settings with a large scale so wraps and clamps come often
    write_regs(DEADBAND_W'($urandom), SCALE_W'($urandom_range(1000, 1048575)));
    tx_idle_pct  = 32;
    rx_stall_pct = 32;
    random_burst(150);
    settle();

    // Anything the block still owed counts as missing
    if (tracker.pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.pending.size());
      tracker.mismatches += tracker.pending.size();
    end
    if (tracker.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
design/gai_pkg.sv
design/gai_axis.sv
design/gyro_angle_integrator.sv
verif/gyro_angle_integrator_tb.sv
